>>> hdl/i2cms_pkg.sv
// Shared types, codes and phase tables of the I2C master bit sequencer.
package i2cms_pkg;

  // Command codes
  typedef enum logic [2:0] {
    ReqStart   = 3'd0,
    ReqStop    = 3'd1,
    ReqWrite   = 3'd2,
    ReqRead    = 3'd3,
    ReqWaitAck = 3'd4,
    ReqAck     = 3'd5,
    ReqNack    = 3'd6
  } req_e;

  // Code with no command behind it: accepted and dropped
  localparam logic [2:0] ReqCodeUnused = 3'd7;

  localparam logic [7:0] HoldDelayReset = 8'd5;
  localparam int unsigned CmdQueueDepth = 2;

  localparam logic [4:0] WriteLastStep = 5'd23;
  localparam logic [4:0] ReadLastStep  = 5'd15;
  localparam logic [1:0] WriteLastSub  = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] line_bits;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       hold_after;
    logic       last_phase;
    logic [7:0] read_data;
    logic       nack_seen;
  } out_t;

  // Classified command as it sits in the queue
  typedef struct packed {
    req_e       req;
    logic [7:0] data;
    logic [7:0] lines;
  } cmd_t;

  // One line phase: which line is written, its new level, hold, end of command
  typedef struct packed {
    logic is_scl;
    logic level;
    logic hold;
    logic last;
  } phase_t;

  // Phase table for the short fixed-pattern commands
  function automatic phase_t fixed_phase(req_e req, logic [1:0] step);
    phase_t p;
    p = '{is_scl: 1'b1, level: 1'b0, hold: 1'b1, last: 1'b1};
    case (req)
      ReqStart: begin
        case (step)
          2'd0:    p = '{is_scl: 1'b0, level: 1'b1, hold: 1'b0, last: 1'b0};
          2'd1:    p = '{is_scl: 1'b1, level: 1'b1, hold: 1'b1, last: 1'b0};
          2'd2:    p = '{is_scl: 1'b0, level: 1'b0, hold: 1'b1, last: 1'b0};
          default: p = '{is_scl: 1'b1, level: 1'b0, hold: 1'b1, last: 1'b1};
        endcase
      end
      ReqStop: begin
        case (step)
          2'd0:    p = '{is_scl: 1'b1, level: 1'b0, hold: 1'b0, last: 1'b0};
          2'd1:    p = '{is_scl: 1'b0, level: 1'b0, hold: 1'b1, last: 1'b0};
          2'd2:    p = '{is_scl: 1'b1, level: 1'b1, hold: 1'b1, last: 1'b0};
          default: p = '{is_scl: 1'b0, level: 1'b1, hold: 1'b0, last: 1'b1};
        endcase
      end
      ReqAck: begin
        case (step)
          2'd0:    p = '{is_scl: 1'b0, level: 1'b0, hold: 1'b1, last: 1'b0};
          2'd1:    p = '{is_scl: 1'b1, level: 1'b1, hold: 1'b1, last: 1'b0};
          2'd2:    p = '{is_scl: 1'b1, level: 1'b0, hold: 1'b1, last: 1'b0};
          default: p = '{is_scl: 1'b0, level: 1'b1, hold: 1'b0, last: 1'b1};
        endcase
      end
      ReqWaitAck, ReqNack: begin
        // release SDA, clock high (ack sampled here), clock low
        case (step)
          2'd0:    p = '{is_scl: 1'b0, level: 1'b1, hold: 1'b1, last: 1'b0};
          2'd1:    p = '{is_scl: 1'b1, level: 1'b1, hold: 1'b1, last: 1'b0};
          default: p = '{is_scl: 1'b1, level: 1'b0, hold: 1'b1, last: 1'b1};
        endcase
      end
      default: p = '{is_scl: 1'b1, level: 1'b0, hold: 1'b1, last: 1'b1};
    endcase
    return p;
  endfunction

endpackage

>>> hdl/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: front end, command queue, phase generator.
//
//  channel  direction  handshake                payload
//  in       input      in_valid_i / in_ready_o  in_data_i  (one bus command)
//  out      output     out_valid_o / out_ready_i out_data_o (one line phase)
//  cfg      input      cfg_we_i                 cfg_wdata_i (hold delay)
//
// One line phase leaves per cycle while out_ready_i is high: a write byte has
// 24 phases, read byte 16, start, stop and send ack 4, wait ack and send nack 3.
// The phase generator's step counter sets these counts; a waiting command is
// loaded as the last phase issues. Unused command codes are taken and dropped.
// Reset releases both lines high and empties the queue. A stalled output holds
// its phase; the queue keeps taking commands until full.
module i2c_master_bit_sequencer #(
  parameter int unsigned CmdQueueDepth = i2cms_pkg::CmdQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  i2cms_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output i2cms_pkg::out_t out_data_o,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i,
  output logic [7:0]      hold_delay_o
);

  logic            push, push_ready, pop, pop_valid;
  i2cms_pkg::cmd_t push_cmd, pop_cmd;
  logic [7:0]      hold_delay_q;

  // bus pacing length for the external delay timer; line phases carry only the hold marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_delay_q <= i2cms_pkg::HoldDelayReset;
    end else if (cfg_we_i) begin
      hold_delay_q <= cfg_wdata_i;
    end
  end

  assign hold_delay_o = hold_delay_q;

  i2cms_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  i2cms_cmd_queue #(
    .Depth (CmdQueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_i        (pop)
  );

  i2cms_phase_gen u_phase_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hdl/i2cms_front.sv
// Front end: takes commands, drops the unused code, hands the rest to the queue.
module i2cms_front (
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  i2cms_pkg::in_t in_data_i,
  output logic            push_o,
  output i2cms_pkg::cmd_t push_cmd_o,
  input  logic            push_ready_i
);

  logic is_cmd;

  assign is_cmd = (in_data_i.req_type != i2cms_pkg::ReqCodeUnused);

  // an unused code is taken at once, even with the queue full
  assign in_ready_o = push_ready_i || !is_cmd;
  assign push_o     = in_valid_i && is_cmd;

  assign push_cmd_o.req   = i2cms_pkg::req_e'(in_data_i.req_type);
  assign push_cmd_o.data  = in_data_i.data_byte;
  assign push_cmd_o.lines = in_data_i.line_bits;

endmodule

>>> hdl/i2cms_cmd_queue.sv
// Short command queue between front end and phase generator.
module i2cms_cmd_queue #(
  parameter int unsigned Depth = i2cms_pkg::CmdQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2cms_pkg::cmd_t push_cmd_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output i2cms_pkg::cmd_t pop_cmd_o,
  input  logic            pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  i2cms_pkg::cmd_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  assign do_push = push_i && push_ready_o;
  assign do_pop  = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> hdl/i2cms_phase_gen.sv
// Back end: steps through the line phases of one command, one phase a cycle while the output is not stalled.
module i2cms_phase_gen (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  i2cms_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output i2cms_pkg::out_t out_data_o
);

  logic                    busy_q, busy_d;
  i2cms_pkg::cmd_t         cmd_q, cmd_d;
  logic [4:0]              step_q, step_d;
  logic [1:0]              sub_q, sub_d;
  logic [7:0]              shift_q, shift_d;
  logic                    scl_q, scl_d, sda_q, sda_d;
  logic                    out_valid_q, out_valid_d;
  i2cms_pkg::out_t         out_q, out_d;
  i2cms_pkg::phase_t       ph;
  logic                    adv, load;

  // phase of the current command at the current step
  always_comb begin
    case (cmd_q.req)
      i2cms_pkg::ReqWrite: begin
        ph.hold = 1'b1;
        ph.last = (step_q == i2cms_pkg::WriteLastStep);
        case (sub_q)
          2'd0: begin
            ph.is_scl = 1'b0;
            ph.level  = shift_q[7];
          end
          2'd1: begin
            ph.is_scl = 1'b1;
            ph.level  = 1'b1;
          end
          default: begin
            ph.is_scl = 1'b1;
            ph.level  = 1'b0;
          end
        endcase
      end
      i2cms_pkg::ReqRead: begin
        // SDA is left as it is; only the clock toggles
        ph.is_scl = 1'b1;
        ph.level  = (sub_q == 2'd0);
        ph.hold   = 1'b1;
        ph.last   = (step_q == i2cms_pkg::ReadLastStep);
      end
      default: ph = i2cms_pkg::fixed_phase(cmd_q.req, step_q[1:0]);
    endcase
  end

  assign adv       = busy_q && (!out_valid_q || out_ready_i);
  assign load      = !busy_q || (adv && ph.last);
  assign cmd_pop_o = load;

  always_comb begin
    busy_d      = busy_q;
    cmd_d       = cmd_q;
    step_d      = step_q;
    sub_d       = sub_q;
    shift_d     = shift_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (adv) begin
      if (ph.is_scl) begin
        scl_d = ph.level;
      end else begin
        sda_d = ph.level;
      end
      out_valid_d      = 1'b1;
      out_d.scl_level  = ph.is_scl ? ph.level : scl_q;
      out_d.sda_level  = ph.is_scl ? sda_q : ph.level;
      out_d.hold_after = ph.hold;
      out_d.last_phase = ph.last;
      out_d.read_data  = (ph.last && cmd_q.req == i2cms_pkg::ReqRead) ? cmd_q.lines : 8'd0;
      out_d.nack_seen  = ph.last && (cmd_q.req == i2cms_pkg::ReqWaitAck) && cmd_q.lines[7];

      step_d = step_q + 5'd1;
      if (cmd_q.req == i2cms_pkg::ReqWrite) begin
        if (sub_q == i2cms_pkg::WriteLastSub) begin
          sub_d   = 2'd0;
          shift_d = {shift_q[6:0], 1'b0};
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end else begin
        sub_d = {1'b0, ~sub_q[0]};
      end
      if (ph.last) begin
        busy_d = 1'b0;
      end
    end

    if (load && cmd_valid_i) begin
      busy_d  = 1'b1;
      cmd_d   = cmd_i;
      step_d  = 5'd0;
      sub_d   = 2'd0;
      shift_d = cmd_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= 5'd0;
      sub_q       <= 2'd0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      sub_q       <= sub_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    shift_q <= shift_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> test/i2c_master_bit_sequencer_test.sv
// Testbench of the I2C master bit sequencer: directed commands, random bus traffic, checks.
module i2c_master_bit_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkHalfPeriod  = 5;
  localparam int ResetCycles    = 12;
  localparam int SettleCycles   = 40;   // longest command is 24 phases
  localparam int LongHoldCycles = 400;
  localparam int CycleLimit     = 400000;
  localparam int ReportLimit    = 10;

  // which line a phase writes
  localparam bit LineScl = 1'b1;
  localparam bit LineSda = 1'b0;

  typedef struct {
    logic [2:0] req;
    logic [7:0] data;
    logic [7:0] lines;
    bit         typed;      // last phase read_data / nack_seen given below
    logic [7:0] want_read;
    logic       want_nack;
  } directed_row_t;

  localparam int DirectedRows = 23;

  directed_row_t directed_rows [DirectedRows] = '{
    // read right after reset: SDA still released
    '{i2cms_pkg::ReqRead,    8'h00, 8'hFF, 1'b1, 8'hFF, 1'b0},
    '{i2cms_pkg::ReqWaitAck, 8'h00, 8'h80, 1'b1, 8'h00, 1'b1},
    '{i2cms_pkg::ReqWaitAck, 8'hFF, 8'h7F, 1'b1, 8'h00, 1'b0},
    '{i2cms_pkg::ReqStart,   8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqWrite,   8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqWrite,   8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqWrite,   8'h5A, 8'h00, 1'b0, 8'h00, 1'b0},
    // SDA left pulled low by the last data bit, read does not release it
    '{i2cms_pkg::ReqRead,    8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
    '{i2cms_pkg::ReqWaitAck, 8'h00, 8'hFF, 1'b1, 8'h00, 1'b1},
    '{i2cms_pkg::ReqWrite,   8'hA5, 8'h5A, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqRead,    8'hFF, 8'h80, 1'b1, 8'h80, 1'b0},
    '{i2cms_pkg::ReqAck,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqRead,    8'h00, 8'h01, 1'b1, 8'h01, 1'b0},
    '{i2cms_pkg::ReqNack,    8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqCodeUnused, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqStart,   8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqStart,   8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqStop,    8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqStop,    8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqCodeUnused, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqNack,    8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqAck,     8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{i2cms_pkg::ReqStop,    8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0}
  };

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  i2cms_pkg::in_t  in_data_i;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  i2cms_pkg::out_t out_data_o;
  logic            cfg_we_i;
  logic [7:0]      cfg_wdata_i;
  logic [7:0]      hold_delay_o;

  i2cms_pkg::out_t pending_phases [$];   // predicted line phases, oldest first
  i2cms_pkg::out_t sampled_phases [$];   // phases taken from the block, not yet compared
  logic            scl_line;
  logic            sda_line;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              mismatch_count = 0;
  int              cycle_count;
  int              stall_left = 0;
  int              long_stall_asked = 0;
  int              long_stall_taken = 0;

  always #ClkHalfPeriod clk_i = ~clk_i;

  i2c_master_bit_sequencer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .hold_delay_o (hold_delay_o)
  );

  // One phase: write one line, report both levels after the write
  function automatic void drive_line(bit on_scl, logic level, logic hold);
    i2cms_pkg::out_t ph;
    if (on_scl) scl_line = level;
    else        sda_line = level;
    ph            = '0;
    ph.scl_level  = scl_line;
    ph.sda_level  = sda_line;
    ph.hold_after = hold;
    pending_phases.push_back(ph);
  endfunction

  function automatic void build_line_phases(i2cms_pkg::in_t cmd);
    i2cms_pkg::out_t tail;
    case (cmd.req_type)
      i2cms_pkg::ReqStart: begin
        drive_line(LineSda, 1'b1, 1'b0);
        drive_line(LineScl, 1'b1, 1'b1);
        drive_line(LineSda, 1'b0, 1'b1);
        drive_line(LineScl, 1'b0, 1'b1);
      end
      i2cms_pkg::ReqStop: begin
        drive_line(LineScl, 1'b0, 1'b0);
        drive_line(LineSda, 1'b0, 1'b1);
        drive_line(LineScl, 1'b1, 1'b1);
        drive_line(LineSda, 1'b1, 1'b0);
      end
      i2cms_pkg::ReqWrite: begin
        for (int b = 7; b >= 0; b--) begin
          drive_line(LineSda, cmd.data_byte[b], 1'b1);
          drive_line(LineScl, 1'b1, 1'b1);
          drive_line(LineScl, 1'b0, 1'b1);
        end
      end
      i2cms_pkg::ReqRead: begin
        repeat (8) begin
          drive_line(LineScl, 1'b1, 1'b1);
          drive_line(LineScl, 1'b0, 1'b1);
        end
      end
      i2cms_pkg::ReqWaitAck, i2cms_pkg::ReqNack: begin
        drive_line(LineSda, 1'b1, 1'b1);
        drive_line(LineScl, 1'b1, 1'b1);
        drive_line(LineScl, 1'b0, 1'b1);
      end
      i2cms_pkg::ReqAck: begin
        drive_line(LineSda, 1'b0, 1'b1);
        drive_line(LineScl, 1'b1, 1'b1);
        drive_line(LineScl, 1'b0, 1'b1);
        drive_line(LineSda, 1'b1, 1'b0);
      end
      default: return;  // unused code: no phases, lines untouched
    endcase
    tail            = pending_phases.pop_back();
    tail.last_phase = 1'b1;
    if (cmd.req_type == i2cms_pkg::ReqRead)    tail.read_data = cmd.line_bits;
    if (cmd.req_type == i2cms_pkg::ReqWaitAck) tail.nack_seen = cmd.line_bits[7];
    pending_phases.push_back(tail);
  endfunction

  // Offer one command and wait for its transfer
  task automatic send_command(input i2cms_pkg::in_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    build_line_phases(cmd);
  endtask

  task automatic send_op(input i2cms_pkg::req_e op, inout int issued);
    i2cms_pkg::in_t cmd;
    cmd.req_type  = op;
    cmd.data_byte = 8'($urandom);
    cmd.line_bits = 8'($urandom);
    send_command(cmd);
    issued++;
  endtask

  // Mostly well-formed transfers (start, address, ack, data, stop), some noise
  task automatic random_transaction(inout int issued);
    i2cms_pkg::in_t cmd;
    int             n_bytes;
    bit             reading;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(4, 1)) begin
        cmd.req_type  = 3'($urandom_range(7));
        cmd.data_byte = 8'($urandom);
        cmd.line_bits = 8'($urandom);
        send_command(cmd);
        if (cmd.req_type != i2cms_pkg::ReqCodeUnused) issued++;
      end
      return;
    end
    reading = 1'($urandom_range(1));
    n_bytes = $urandom_range(4, 1);
    send_op(i2cms_pkg::ReqStart, issued);
    send_op(i2cms_pkg::ReqWrite, issued);
    send_op(i2cms_pkg::ReqWaitAck, issued);
    for (int k = 0; k < n_bytes; k++) begin
      if (reading) begin
        send_op(i2cms_pkg::ReqRead, issued);
        send_op((k == n_bytes - 1) ? i2cms_pkg::ReqNack : i2cms_pkg::ReqAck, issued);
      end else begin
        send_op(i2cms_pkg::ReqWrite, issued);
        send_op(i2cms_pkg::ReqWaitAck, issued);
      end
    end
    // now and then leave the bus held for a repeated start
    if ($urandom_range(9) != 0) send_op(i2cms_pkg::ReqStop, issued);
  endtask

  task automatic run_transactions(input int target);
    int issued;
    issued = 0;
    while (issued < target) random_transaction(issued);
  endtask

  task automatic write_hold_delay(input logic [7:0] units);
    cfg_wdata_i <= units;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // drop valid so the last command is not offered again, then drain
  task automatic wait_bus_quiet();
    in_valid_i <= 1'b0;
    while (pending_phases.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void flag_phase(string why, i2cms_pkg::out_t want,
                                     i2cms_pkg::out_t got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit)
      $display({"%s: expected scl=%0b sda=%0b hold=%0b last=%0b rd=%02h nack=%0b,",
                " got scl=%0b sda=%0b hold=%0b last=%0b rd=%02h nack=%0b"},
               why, want.scl_level, want.sda_level, want.hold_after, want.last_phase,
               want.read_data, want.nack_seen, got.scl_level, got.sda_level,
               got.hold_after, got.last_phase, got.read_data, got.nack_seen);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (long_stall_asked != long_stall_taken) begin
      long_stall_taken = long_stall_asked;
      stall_left       = LongHoldCycles;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sampled_phases.push_back(out_data_o);
  end

  // Compared on the falling edge so the prediction of the same rising edge is in place
  always @(negedge clk_i) begin
    i2cms_pkg::out_t got;
    i2cms_pkg::out_t want;
    while (sampled_phases.size() != 0) begin
      got = sampled_phases.pop_front();
      if (pending_phases.size() == 0) begin
        flag_phase("unexpected phase", '0, got);
      end else begin
        want = pending_phases.pop_front();
        if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
            got.hold_after !== want.hold_after || got.last_phase !== want.last_phase ||
            got.read_data !== want.read_data || got.nack_seen !== want.nack_seen)
          flag_phase("phase mismatch", want, got);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    i2cms_pkg::in_t  cmd;
    i2cms_pkg::out_t tail;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    scl_line      = 1'b1;
    sda_line      = 1'b1;
    send_idle_pct = 16;
    recv_idle_pct = 81;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_hold_delay(8'd1);
    foreach (directed_rows[r]) begin
      cmd.req_type  = directed_rows[r].req;
      cmd.data_byte = directed_rows[r].data;
      cmd.line_bits = directed_rows[r].lines;
      send_command(cmd);
      if (directed_rows[r].typed) begin
        tail           = pending_phases.pop_back();
        tail.read_data = directed_rows[r].want_read;
        tail.nack_seen = directed_rows[r].want_nack;
        pending_phases.push_back(tail);
      end
    end
    wait_bus_quiet();

    write_hold_delay(8'd255);
    run_transactions(40);
    // sender holds back until the bus has drained
    in_valid_i <= 1'b0;
    wait_bus_quiet();
    run_transactions(40);
    wait_bus_quiet();

    write_hold_delay(8'd0);
    send_idle_pct = 81;
    recv_idle_pct = 16;
    run_transactions(90);
    wait_bus_quiet();

    write_hold_delay(8'($urandom_range(254, 2)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long receiver hold-off while commands keep coming: queue fills, input stalls
    @(negedge clk_i);
    long_stall_asked++;
    @(posedge clk_i);
    run_transactions(100);

    in_valid_i <= 1'b0;
    wait_bus_quiet();
    if (mismatch_count == 0 && pending_phases.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> i2c_master_bit_sequencer.f
hdl/i2cms_pkg.sv
hdl/i2cms_front.sv
hdl/i2cms_cmd_queue.sv
hdl/i2cms_phase_gen.sv
hdl/i2c_master_bit_sequencer.sv
test/i2c_master_bit_sequencer_test.sv
